// ===== hdl/rhc_pkg.sv =====
`timescale 1ns / 1ps

package rhc_pkg;

    // quotient bits resolved by the divide pipeline, one per stage
    localparam int QuotBits = 8;

    localparam logic [8:0] HueGreenOffset = 9'd120;
    localparam logic [8:0] HueBlueOffset  = 9'd240;
    localparam logic [8:0] HueCircle      = 9'd360;
    localparam logic [7:0] LightHalf      = 8'd128;
    localparam logic [9:0] DoubleScale    = 10'd510;

    // which channel holds the maximum, red wins ties, then green
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    // front stage: extremes and hue difference
    typedef struct packed {
        logic [7:0] hi;
        logic [7:0] lo;
        sector_t    sector;
        logic [7:0] diff_mag;
        logic       diff_neg;
    } front_t;

    // divide stage: two restoring dividers run side by side
    typedef struct packed {
        logic [15:0] sat_rem;
        logic [8:0]  sat_den;
        logic [7:0]  sat_q;
        logic [13:0] hue_rem;
        logic [7:0]  hue_den;
        logic [7:0]  hue_q;
        logic        hue_neg;
        sector_t     sector;
        logic [7:0]  light;
        logic        grey;
    } div_t;

    // one quotient bit of both divisions at bit position k
    function automatic div_t div_step(div_t d, int unsigned k);
        logic [16:0] sat_sh;
        logic [14:0] hue_sh;
        div_t        r;
        sat_sh = 17'(d.sat_den) << k;
        hue_sh = 15'(d.hue_den) << k;
        r = d;
        if ({1'b0, d.sat_rem} >= sat_sh)
        begin
            r.sat_rem  = d.sat_rem - sat_sh[15:0];
            r.sat_q[k] = 1'b1;
        end
        if ({1'b0, d.hue_rem} >= hue_sh)
        begin
            r.hue_rem  = d.hue_rem - hue_sh[13:0];
            r.hue_q[k] = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== hdl/rgb_to_hls_converter_unit.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                fields
// pixel     in         in_valid / in_ready      red[7:0] green[7:0] blue[7:0]
// hls       out        out_valid / out_ready    hue[8:0] lightness[7:0] saturation[7:0]
//
// pipeline: a front stage, a divider setup stage, 8 divide stages, an output register
// one pixel per clock while out_ready keeps the output moving; each divide stage resolves one quotient bit
// each stage holds its own valid bit, so bubbles close up while out_ready is low
// in_ready falls only when every stage holds a pixel and the output is stalled
// reset clears the valid bits; payload registers are not reset

module rgb_to_hls_converter_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [8:0] hue,
    output logic [7:0] lightness,
    output logic [7:0] saturation
);

    localparam int Q = rhc_pkg::QuotBits;

    rhc_pkg::front_t fr_reg;
    rhc_pkg::front_t fr_next;
    logic            fr_valid_reg;
    logic            fr_load;

    rhc_pkg::div_t   dv_reg [Q+1];
    rhc_pkg::div_t   dv_next [Q+1];
    logic [Q:0]      dv_valid_reg;
    logic [Q:0]      dv_load;

    logic            out_valid_reg;
    logic            out_load;
    logic [8:0]      hue_reg;
    logic [8:0]      hue_next;
    logic [7:0]      light_reg;
    logic [7:0]      sat_reg;

    // ready chain, back to front
    assign out_load = !out_valid_reg || out_ready;
    assign dv_load[Q] = !dv_valid_reg[Q] || out_load;

    genvar gi;
    generate
        for (gi = 0; gi < Q; gi++)
        begin : g_load
            assign dv_load[gi] = !dv_valid_reg[gi] || dv_load[gi+1];
        end
    endgenerate

    assign fr_load  = !fr_valid_reg || dv_load[0];
    assign in_ready = fr_load;

    // front: max, min, sector and signed hue difference
    always_comb
    begin
        logic [7:0] hi;
        logic [7:0] lo;
        logic [8:0] diff;
        hi = red;
        if (green > hi)
            hi = green;
        if (blue > hi)
            hi = blue;
        lo = red;
        if (green < lo)
            lo = green;
        if (blue < lo)
            lo = blue;
        fr_next.hi = hi;
        fr_next.lo = lo;
        priority if (red == hi)
        begin
            fr_next.sector = rhc_pkg::SECT_RED;
            diff = {1'b0, green} - {1'b0, blue};
        end
        else if (green == hi)
        begin
            fr_next.sector = rhc_pkg::SECT_GREEN;
            diff = {1'b0, blue} - {1'b0, red};
        end
        else
        begin
            fr_next.sector = rhc_pkg::SECT_BLUE;
            diff = {1'b0, red} - {1'b0, green};
        end
        fr_next.diff_neg = diff[8];
        fr_next.diff_mag = diff[8] ? 8'(-diff) : diff[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fr_valid_reg <= 1'b0;
        else if (fr_load)
            fr_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (fr_load && in_valid)
            fr_reg <= fr_next;
    end

    // divider setup: lightness, divisors and scaled numerators
    always_comb
    begin
        logic [7:0]  delta;
        logic [8:0]  sum;
        logic [13:0] mag;
        delta = fr_reg.hi - fr_reg.lo;
        sum   = {1'b0, fr_reg.hi} + {1'b0, fr_reg.lo};
        mag   = 14'(fr_reg.diff_mag);
        dv_next[0].light   = sum[8:1];
        dv_next[0].grey    = (fr_reg.hi == fr_reg.lo);
        dv_next[0].sector  = fr_reg.sector;
        dv_next[0].hue_neg = fr_reg.diff_neg;
        dv_next[0].sat_den = (sum[8:1] < rhc_pkg::LightHalf) ? sum
                           : 9'(rhc_pkg::DoubleScale - {1'b0, sum});
        // delta * 255 and mag * 60 by shift and subtract
        dv_next[0].sat_rem = {delta, 8'h00} - 16'(delta);
        dv_next[0].hue_rem = (mag << 6) - (mag << 2);
        dv_next[0].hue_den = delta;
        dv_next[0].sat_q   = '0;
        dv_next[0].hue_q   = '0;
    end

    // one quotient bit per stage, most significant first
    generate
        for (gi = 0; gi < Q; gi++)
        begin : g_div
            assign dv_next[gi+1] = rhc_pkg::div_step(dv_reg[gi], Q - 1 - gi);
        end

        for (gi = 0; gi <= Q; gi++)
        begin : g_stage
            logic src_valid;
            if (gi == 0)
            begin : g_first
                assign src_valid = fr_valid_reg;
            end
            else
            begin : g_rest
                assign src_valid = dv_valid_reg[gi-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_valid_reg[gi] <= 1'b0;
                else if (dv_load[gi])
                    dv_valid_reg[gi] <= src_valid;
            end

            always_ff @(posedge clk)
            begin
                if (dv_load[gi] && src_valid)
                    dv_reg[gi] <= dv_next[gi];
            end
        end
    endgenerate

    // hue from sector offset and signed quotient, wrapping negatives
    always_comb
    begin
        logic [8:0] q;
        q = 9'(dv_reg[Q].hue_q);
        if (dv_reg[Q].grey)
            hue_next = '0;
        else
        begin
            unique case (dv_reg[Q].sector)
                rhc_pkg::SECT_RED:
                    hue_next = (dv_reg[Q].hue_neg && (q != '0)) ? rhc_pkg::HueCircle - q : q;
                rhc_pkg::SECT_GREEN:
                    hue_next = dv_reg[Q].hue_neg ? rhc_pkg::HueGreenOffset - q
                                                 : rhc_pkg::HueGreenOffset + q;
                rhc_pkg::SECT_BLUE:
                    hue_next = dv_reg[Q].hue_neg ? rhc_pkg::HueBlueOffset - q
                                                 : rhc_pkg::HueBlueOffset + q;
                default:
                    hue_next = '0;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= dv_valid_reg[Q];
    end

    always_ff @(posedge clk)
    begin
        if (out_load && dv_valid_reg[Q])
        begin
            hue_reg   <= hue_next;
            light_reg <= dv_reg[Q].light;
            sat_reg   <= dv_reg[Q].grey ? 8'h00 : dv_reg[Q].sat_q;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hue        = hue_reg;
    assign lightness  = light_reg;
    assign saturation = sat_reg;

    // a stalled input means every stage is full
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (fr_valid_reg && (&dv_valid_reg) && out_valid_reg))
        else $error("input stalled with a bubble in the pipeline");

    // hue quotient never exceeds one sector
    assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[Q] && !dv_reg[Q].grey) |-> (dv_reg[Q].hue_q <= 8'd60))
        else $error("hue quotient beyond 60");

    // saturation division finishes with remainder below divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[Q] && !dv_reg[Q].grey) |-> (dv_reg[Q].sat_rem < 16'(dv_reg[Q].sat_den)))
        else $error("saturation remainder not reduced");

    // delivered hue stays on the circle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (hue_reg < rhc_pkg::HueCircle))
        else $error("hue out of range");

endmodule
